// File: hdl/hsvrgb_pkg.sv
// hsvrgb_pkg: shared types, constants and helper functions for the hsv to rgb pipeline
// no dependencies; used by the interfaces and all pipeline modules

package hsvrgb_pkg;

  localparam int unsigned ChanWidth    = 8;
  localparam int unsigned ProdWidth    = 2 * ChanWidth;
  localparam int unsigned HueRegionDiv = 43;
  localparam int unsigned RemScale     = 6;
  localparam logic [ChanWidth-1:0] Full = 8'd255;

  typedef logic [ChanWidth-1:0] chan_t;
  typedef logic [ProdWidth-1:0] prod_t;

  // six sectors of the color wheel
  typedef enum logic [2:0] {
    REGION_RED_YEL = 3'd0,
    REGION_YEL_GRN = 3'd1,
    REGION_GRN_CYN = 3'd2,
    REGION_CYN_BLU = 3'd3,
    REGION_BLU_MAG = 3'd4,
    REGION_MAG_RED = 3'd5
  } region_t;

  // after products: region, value and the three raw products
  typedef struct packed {
    region_t region;
    chan_t   val;
    prod_t   p_prod;
    prod_t   sq_prod;
    prod_t   st_prod;
  } front_pay_t;

  // after second multiply: region, value, p and the raw q/t products
  typedef struct packed {
    region_t region;
    chan_t   val;
    chan_t   p;
    prod_t   q_prod;
    prod_t   t_prod;
  } level_pay_t;

  // hue / 43 by threshold compare
  function automatic region_t hue_region(input chan_t hue);
    region_t r;
    priority if (hue >= 8'd215) r = REGION_MAG_RED;
    else if (hue >= 8'd172)     r = REGION_BLU_MAG;
    else if (hue >= 8'd129)     r = REGION_CYN_BLU;
    else if (hue >= 8'd86)      r = REGION_GRN_CYN;
    else if (hue >= 8'd43)      r = REGION_YEL_GRN;
    else                        r = REGION_RED_YEL;
    return r;
  endfunction

  // first hue of each region (region * 43)
  function automatic chan_t region_base(input region_t region);
    chan_t b;
    unique case (region)
      REGION_RED_YEL: b = 8'd0;
      REGION_YEL_GRN: b = 8'd43;
      REGION_GRN_CYN: b = 8'd86;
      REGION_CYN_BLU: b = 8'd129;
      REGION_BLU_MAG: b = 8'd172;
      REGION_MAG_RED: b = 8'd215;
      default:        b = 8'd0;
    endcase
    return b;
  endfunction

  // truncating x / 255, exact for x up to 255*255
  function automatic chan_t div255(input prod_t x);
    logic [ProdWidth:0] sum;
    sum = {1'b0, x} + {{(ProdWidth + 1 - ChanWidth){1'b0}}, x[ProdWidth-1:ChanWidth]}
          + {{ProdWidth{1'b0}}, 1'b1};
    return sum[ProdWidth-1:ChanWidth];
  endfunction

endpackage

// File: hdl/hsvrgb_if.sv
// hsvrgb_in_if / hsvrgb_out_if: valid/ready channels for hsv pixels in and rgb pixels out
// depends on hsvrgb_pkg for the channel type

interface hsvrgb_in_if;
  logic              valid;
  logic              ready;
  hsvrgb_pkg::chan_t hue;
  hsvrgb_pkg::chan_t saturation;
  hsvrgb_pkg::chan_t brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsvrgb_out_if;
  logic              valid;
  logic              ready;
  hsvrgb_pkg::chan_t red;
  hsvrgb_pkg::chan_t green;
  hsvrgb_pkg::chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: hdl/hsvrgb_front.sv
// hsvrgb_front: stages 1-2, hue region split and first products
// depends on hsvrgb_pkg

module hsvrgb_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  hsvrgb_pkg::chan_t       hue,
  input  hsvrgb_pkg::chan_t       saturation,
  input  hsvrgb_pkg::chan_t       brightness,
  output logic                    out_valid,
  output hsvrgb_pkg::front_pay_t  out_pay
);

  logic                s1_valid_r;
  hsvrgb_pkg::region_t s1_region_r, s1_region_nxt;
  hsvrgb_pkg::chan_t   s1_rem_r, s1_rem_nxt;
  hsvrgb_pkg::chan_t   s1_sat_r;
  hsvrgb_pkg::chan_t   s1_val_r;

  logic                   s2_valid_r;
  hsvrgb_pkg::front_pay_t s2_pay_r, s2_pay_nxt;

  hsvrgb_pkg::chan_t rem_raw;

  always_comb begin
    s1_region_nxt = hsvrgb_pkg::hue_region(hue);
    rem_raw       = hue - hsvrgb_pkg::region_base(s1_region_nxt);
    // rem * 6 as two shifts, at most 252
    s1_rem_nxt    = {rem_raw[6:0], 1'b0} + {rem_raw[5:0], 2'b00};
  end

  always_comb begin
    s2_pay_nxt.region  = s1_region_r;
    s2_pay_nxt.val     = s1_val_r;
    s2_pay_nxt.p_prod  = hsvrgb_pkg::prod_t'(s1_val_r)
                         * hsvrgb_pkg::prod_t'(hsvrgb_pkg::Full - s1_sat_r);
    s2_pay_nxt.sq_prod = hsvrgb_pkg::prod_t'(s1_sat_r) * hsvrgb_pkg::prod_t'(s1_rem_r);
    s2_pay_nxt.st_prod = hsvrgb_pkg::prod_t'(s1_sat_r)
                         * hsvrgb_pkg::prod_t'(hsvrgb_pkg::Full - s1_rem_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_region_r <= s1_region_nxt;
      s1_rem_r    <= s1_rem_nxt;
      s1_sat_r    <= saturation;
      s1_val_r    <= brightness;
      s2_pay_r    <= s2_pay_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_pay   = s2_pay_r;

endmodule

// File: hdl/hsvrgb_level.sv
// hsvrgb_level: stages 3-4, divide by 255 and second products for q and t
// depends on hsvrgb_pkg

module hsvrgb_level (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  hsvrgb_pkg::front_pay_t  in_pay,
  output logic                    out_valid,
  output hsvrgb_pkg::level_pay_t  out_pay
);

  logic                s3_valid_r;
  hsvrgb_pkg::region_t s3_region_r;
  hsvrgb_pkg::chan_t   s3_val_r;
  hsvrgb_pkg::chan_t   s3_p_r, s3_p_nxt;
  hsvrgb_pkg::chan_t   s3_aq_r, s3_aq_nxt;
  hsvrgb_pkg::chan_t   s3_at_r, s3_at_nxt;

  logic                   s4_valid_r;
  hsvrgb_pkg::level_pay_t s4_pay_r, s4_pay_nxt;

  always_comb begin
    s3_p_nxt  = hsvrgb_pkg::div255(in_pay.p_prod);
    s3_aq_nxt = hsvrgb_pkg::Full - hsvrgb_pkg::div255(in_pay.sq_prod);
    s3_at_nxt = hsvrgb_pkg::Full - hsvrgb_pkg::div255(in_pay.st_prod);
  end

  always_comb begin
    s4_pay_nxt.region = s3_region_r;
    s4_pay_nxt.val    = s3_val_r;
    s4_pay_nxt.p      = s3_p_r;
    s4_pay_nxt.q_prod = hsvrgb_pkg::prod_t'(s3_val_r) * hsvrgb_pkg::prod_t'(s3_aq_r);
    s4_pay_nxt.t_prod = hsvrgb_pkg::prod_t'(s3_val_r) * hsvrgb_pkg::prod_t'(s3_at_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= in_valid;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_region_r <= in_pay.region;
      s3_val_r    <= in_pay.val;
      s3_p_r      <= s3_p_nxt;
      s3_aq_r     <= s3_aq_nxt;
      s3_at_r     <= s3_at_nxt;
      s4_pay_r    <= s4_pay_nxt;
    end
  end

  assign out_valid = s4_valid_r;
  assign out_pay   = s4_pay_r;

endmodule

// File: hdl/hsvrgb_select.sv
// hsvrgb_select: stage 5, final divide by 255 and six-way channel select into the output register
// depends on hsvrgb_pkg

module hsvrgb_select (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  hsvrgb_pkg::level_pay_t  in_pay,
  output logic                    out_valid,
  output hsvrgb_pkg::chan_t       red,
  output hsvrgb_pkg::chan_t       green,
  output hsvrgb_pkg::chan_t       blue
);

  logic              s5_valid_r;
  hsvrgb_pkg::chan_t red_r, red_nxt;
  hsvrgb_pkg::chan_t green_r, green_nxt;
  hsvrgb_pkg::chan_t blue_r, blue_nxt;

  hsvrgb_pkg::chan_t v, p, q, t;

  always_comb begin
    v = in_pay.val;
    p = in_pay.p;
    q = hsvrgb_pkg::div255(in_pay.q_prod);
    t = hsvrgb_pkg::div255(in_pay.t_prod);
    unique case (in_pay.region)
      hsvrgb_pkg::REGION_RED_YEL: begin red_nxt = v; green_nxt = t; blue_nxt = p; end
      hsvrgb_pkg::REGION_YEL_GRN: begin red_nxt = q; green_nxt = v; blue_nxt = p; end
      hsvrgb_pkg::REGION_GRN_CYN: begin red_nxt = p; green_nxt = v; blue_nxt = t; end
      hsvrgb_pkg::REGION_CYN_BLU: begin red_nxt = p; green_nxt = q; blue_nxt = v; end
      hsvrgb_pkg::REGION_BLU_MAG: begin red_nxt = t; green_nxt = p; blue_nxt = v; end
      default:                    begin red_nxt = v; green_nxt = p; blue_nxt = q; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = s5_valid_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

endmodule

// File: hdl/hsv_to_rgb_8bit.sv
// hsv_to_rgb_8bit: top level, 8-bit hsv to rgb pixel converter, five register stages
// depends on hsvrgb_pkg, hsvrgb_if, hsvrgb_front, hsvrgb_level, hsvrgb_select
//
//   channel   dir  fields                          handshake
//   in_pix    in   hue, saturation, brightness     valid/ready
//   out_pix   out  red, green, blue                valid/ready
//
// one pixel per cycle sustained while out_pix is not stalled; from input transfer to output valid
// a pixel passes the hue split stage, the two multiply stages and the two divide-by-255 stages.
// rst_n is synchronous and clears only the stage valid bits.
// the whole pipeline advances when the output register is empty or being taken;
// while out_pix is stalled with valid high, every stage holds and in_pix.ready is low.

module hsv_to_rgb_8bit (
  input  logic                clk,
  input  logic                rst_n,
  hsvrgb_in_if.sink           in_pix,
  hsvrgb_out_if.source        out_pix
);

  logic                   en;
  logic                   front_valid;
  hsvrgb_pkg::front_pay_t front_pay;
  logic                   level_valid;
  hsvrgb_pkg::level_pay_t level_pay;
  logic                   sel_valid;

  assign en           = !sel_valid || out_pix.ready;
  assign in_pix.ready = en;

  hsvrgb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_pix.valid),
    .hue        (in_pix.hue),
    .saturation (in_pix.saturation),
    .brightness (in_pix.brightness),
    .out_valid  (front_valid),
    .out_pay    (front_pay)
  );

  hsvrgb_level u_level (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (front_valid),
    .in_pay    (front_pay),
    .out_valid (level_valid),
    .out_pay   (level_pay)
  );

  hsvrgb_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (level_valid),
    .in_pay    (level_pay),
    .out_valid (sel_valid),
    .red       (out_pix.red),
    .green     (out_pix.green),
    .blue      (out_pix.blue)
  );

  assign out_pix.valid = sel_valid;

endmodule

// File: bench/hsv_to_rgb_8bit_tb.sv
// hsv_to_rgb_8bit_tb: self-checking bench for the hsv to rgb pixel converter, directed
// region edges and grey/black pixels, then random pixels under several idle/stall mixes
// depends on hsvrgb_pkg, hsvrgb_if and hsv_to_rgb_8bit

module hsv_to_rgb_8bit_tb;

  typedef struct packed {
    hsvrgb_pkg::chan_t red;
    hsvrgb_pkg::chan_t green;
    hsvrgb_pkg::chan_t blue;
  } rgb_t;

  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned SettleCycles  = 10;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseItems    = 110;

  logic clk;
  logic rst_n;

  hsvrgb_in_if  in_pix();
  hsvrgb_out_if out_pix();

  hsv_to_rgb_8bit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_pix (out_pix)
  );

  rgb_t        rgb_expected_q[$];
  int unsigned mismatch_count     = 0;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned quiet_cycles       = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // integer hsv to rgb with truncating divides by 255
  function automatic rgb_t predict_rgb(input hsvrgb_pkg::chan_t hue,
                                       input hsvrgb_pkg::chan_t sat,
                                       input hsvrgb_pkg::chan_t bright);
    int unsigned         h, s, v, rem, lvl_p, lvl_q, lvl_t;
    hsvrgb_pkg::region_t sector;
    hsvrgb_pkg::chan_t   cv, cp, cq, ct;
    rgb_t                rgb;
    h      = hue;
    s      = sat;
    v      = bright;
    sector = hsvrgb_pkg::region_t'(h / hsvrgb_pkg::HueRegionDiv);
    rem    = (h % hsvrgb_pkg::HueRegionDiv) * hsvrgb_pkg::RemScale;
    lvl_p  = (v * (255 - s)) / 255;
    lvl_q  = (v * (255 - (s * rem) / 255)) / 255;
    lvl_t  = (v * (255 - (s * (255 - rem)) / 255)) / 255;
    cv     = hsvrgb_pkg::chan_t'(v);
    cp     = hsvrgb_pkg::chan_t'(lvl_p);
    cq     = hsvrgb_pkg::chan_t'(lvl_q);
    ct     = hsvrgb_pkg::chan_t'(lvl_t);
    case (sector)
      hsvrgb_pkg::REGION_RED_YEL: rgb = '{cv, ct, cp};
      hsvrgb_pkg::REGION_YEL_GRN: rgb = '{cq, cv, cp};
      hsvrgb_pkg::REGION_GRN_CYN: rgb = '{cp, cv, ct};
      hsvrgb_pkg::REGION_CYN_BLU: rgb = '{cp, cq, cv};
      hsvrgb_pkg::REGION_BLU_MAG: rgb = '{ct, cp, cv};
      default:                    rgb = '{cv, cp, cq};
    endcase
    return rgb;
  endfunction

  task automatic send_pixel(input hsvrgb_pkg::chan_t hue, input hsvrgb_pkg::chan_t sat,
                            input hsvrgb_pkg::chan_t bright);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_pix.valid <= 1'b0;
      @(posedge clk);
    end
    in_pix.valid      <= 1'b1;
    in_pix.hue        <= hue;
    in_pix.saturation <= sat;
    in_pix.brightness <= bright;
    @(posedge clk);
    while (in_pix.ready !== 1'b1) @(posedge clk);
    rgb_expected_q.push_back(predict_rgb(hue, sat, bright));
  endtask

  // sender holds off until the pipeline has handed back every pixel
  task automatic wait_rgb_drain();
    in_pix.valid <= 1'b0;
    do @(posedge clk); while (rgb_expected_q.size() != 0);
  endtask

  task automatic test_region_boundaries();
    hsvrgb_pkg::chan_t boundary_hues [12] = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd128,
                                              8'd129, 8'd171, 8'd172, 8'd214, 8'd215,
                                              8'd255};
    foreach (boundary_hues[i]) send_pixel(boundary_hues[i], 8'd255, 8'd255);
  endtask

  task automatic test_saturation_and_value();
    send_pixel(8'd100, 8'd0,   8'd200);  // grey
    send_pixel(8'd250, 8'd0,   8'd255);
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd30,  8'd255, 8'd0);    // black despite full saturation
    send_pixel(8'd215, 8'd128, 8'd77);
    send_pixel(8'd255, 8'd1,   8'd254);
    send_pixel(8'd128, 8'd254, 8'd1);
    send_pixel(8'd170, 8'd85,  8'd170);
    send_pixel(8'd85,  8'd170, 8'd85);
  endtask

  task automatic test_random_pixels(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned count);
    hsvrgb_pkg::chan_t h, s, v;
    wait_rgb_drain();
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) begin
      h = hsvrgb_pkg::chan_t'($urandom_range(255));
      s = hsvrgb_pkg::chan_t'($urandom_range(255));
      v = hsvrgb_pkg::chan_t'($urandom_range(255));
      // lean on the corners now and then
      case ($urandom_range(7))
        0:       s = 8'd0;
        1:       s = 8'd255;
        2:       v = 8'd255;
        3:       h = hsvrgb_pkg::chan_t'($urandom_range(255, 215));
        default: ;
      endcase
      send_pixel(h, s, v);
    end
  endtask

  // result side: random stalls and comparison against the oldest prediction
  initial begin
    rgb_t got, want;
    out_pix.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_pix.valid === 1'b1 && out_pix.ready === 1'b1) begin
        got = '{out_pix.red, out_pix.green, out_pix.blue};
        if (rgb_expected_q.size() == 0) begin
          $display("%0t: unexpected rgb result %0d %0d %0d", $time,
                   got.red, got.green, got.blue);
          mismatch_count++;
        end else begin
          want = rgb_expected_q.pop_front();
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            $display("%0t: rgb mismatch, expected %0d %0d %0d, actual %0d %0d %0d", $time,
                     want.red, want.green, want.blue, got.red, got.green, got.blue);
            mismatch_count++;
          end
        end
      end
      out_pix.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    forever begin
      @(posedge clk);
      if ((in_pix.valid === 1'b1 && in_pix.ready === 1'b1) ||
          (out_pix.valid === 1'b1 && out_pix.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_pix.valid      <= 1'b0;
    in_pix.hue        <= '0;
    in_pix.saturation <= '0;
    in_pix.brightness <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    test_region_boundaries();
    test_saturation_and_value();
    test_random_pixels(0, 0, PhaseItems);
    test_random_pixels(72, 0, PhaseItems);
    test_random_pixels(0, 72, PhaseItems);
    test_random_pixels(9, 9, PhaseItems);

    wait_rgb_drain();
    repeat (SettleCycles) @(posedge clk);
    if (rgb_expected_q.size() != 0) begin
      $display("%0t: %0d rgb results never arrived", $time, rgb_expected_q.size());
      mismatch_count += rgb_expected_q.size();
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
